// File: hdl/lppf_pkg.sv
`timescale 1ns / 1ps

package lppf_pkg;

  // Store geometry and packet limits
  localparam int DEPTH      = 4096;
  localparam int MAX_PACKET = 2047;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int LEN_W      = 11;
  localparam int BYTE_W     = 8;
  localparam int OP_W       = 2;
  localparam int STAT_W     = 2;

  // Width for the fit check: free space, length + 2 and the packet limit
  localparam int MAXP_W = $clog2(MAX_PACKET + 1);
  localparam int CMP_A  = (PTR_W + 1 > LEN_W + 1) ? PTR_W + 1 : LEN_W + 1;
  localparam int CMP_W  = (CMP_A > MAXP_W + 1) ? CMP_A : MAXP_W + 1;

  // Stream word widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((LEN_W + BYTE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((LEN_W + BYTE_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_WDATA = 2'd1,
    OP_RHDR  = 2'd2,
    OP_RDATA = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_ORDER = 2'd3
  } status_t;

  // Controller to datapath: one step per cycle, unless a held result stalls it
  typedef struct packed {
    logic load;          // latch the accepted word
    logic start_reject;  // start refused, drop its bytes
    logic start_hdr_hi;  // store length high byte
    logic start_hdr_lo;  // store length low byte, open packet
    logic data_store;    // store one data byte
    logic data_drop;     // drop one data byte
    logic rd_hdr_hi;     // read length high byte
    logic rd_hdr_lo;     // read length low byte, keep high byte
    logic hdr_done;      // finish header read
    logic rd_byte;       // read one data byte
    logic byte_done;     // finish data read
    logic seq_err;       // out-of-order word
    logic fifo_empty;    // nothing committed to read
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic wl_zero;
    logic rl_zero;
    logic wr_drop;
    logic fits;
    logic fifo_empty;
    logic out_free;
  } stat_t;

endpackage

// File: hdl/lppf_ram.sv
`timescale 1ns / 1ps

module lppf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/lppf_ctrl.sv
`timescale 1ns / 1ps

module lppf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  lppf_pkg::stat_t stat,
  output lppf_pkg::cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_WHDR  = 6'b000100,
    S_RHDR  = 6'b001000,
    S_RLEN  = 6'b010000,
    S_RBYTE = 6'b100000
  } fsm_t;

  fsm_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // sequencing of one word
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      // wait here until the result register can take a word
      S_EXEC: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
          case (stat.op)
            lppf_pkg::OP_START: begin
              if (!stat.wl_zero) begin
                cmd.seq_err = 1'b1;
              end else if (!stat.fits) begin
                cmd.start_reject = 1'b1;
              end else begin
                cmd.start_hdr_hi = 1'b1;
                state_nxt        = S_WHDR;
              end
            end
            lppf_pkg::OP_WDATA: begin
              if (stat.wl_zero) begin
                cmd.seq_err = 1'b1;
              end else if (stat.wr_drop) begin
                cmd.data_drop = 1'b1;
              end else begin
                cmd.data_store = 1'b1;
              end
            end
            lppf_pkg::OP_RHDR: begin
              if (!stat.rl_zero) begin
                cmd.seq_err = 1'b1;
              end else if (stat.fifo_empty) begin
                cmd.fifo_empty = 1'b1;
              end else begin
                cmd.rd_hdr_hi = 1'b1;
                state_nxt     = S_RHDR;
              end
            end
            lppf_pkg::OP_RDATA: begin
              if (stat.rl_zero) begin
                cmd.seq_err = 1'b1;
              end else begin
                cmd.rd_byte = 1'b1;
                state_nxt   = S_RBYTE;
              end
            end
            default: begin
              cmd.seq_err = 1'b1;
            end
          endcase
        end
      end
      S_WHDR: begin
        cmd.start_hdr_lo = 1'b1;
        state_nxt        = S_IDLE;
      end
      S_RHDR: begin
        cmd.rd_hdr_lo = 1'b1;
        state_nxt     = S_RLEN;
      end
      S_RLEN: begin
        cmd.hdr_done = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_RBYTE: begin
        cmd.byte_done = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hdl/lppf_dp.sv
`timescale 1ns / 1ps

module lppf_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lppf_pkg::cmd_t                  cmd,
  output lppf_pkg::stat_t                 stat,
  input  lppf_pkg::op_t                   in_op,
  input  logic [lppf_pkg::LEN_W-1:0]      in_len,
  input  logic [lppf_pkg::BYTE_W-1:0]     in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lppf_pkg::status_t               out_status,
  output logic [lppf_pkg::LEN_W-1:0]      out_len,
  output logic [lppf_pkg::BYTE_W-1:0]     out_byte,
  output logic                            out_last
);

  localparam int PTR_W  = lppf_pkg::PTR_W;
  localparam int LEN_W  = lppf_pkg::LEN_W;
  localparam int BYTE_W = lppf_pkg::BYTE_W;
  localparam int CMP_W  = lppf_pkg::CMP_W;

  // ring step with wrap at the store depth
  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    begin
      n = (p == PTR_W'(lppf_pkg::DEPTH - 1)) ? '0 : p + 1'b1;
      return n;
    end
  endfunction

  // latched word
  lppf_pkg::op_t       op_r;
  logic [LEN_W-1:0]    len_r;
  logic [BYTE_W-1:0]   data_r;

  // pointers and counters
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [PTR_W-1:0] com_r, com_nxt;
  logic [LEN_W-1:0] wl_r, wl_nxt;
  logic [LEN_W-1:0] rl_r, rl_nxt;
  logic             drop_r, drop_nxt;
  logic [BYTE_W-1:0] hi_r;

  // result register
  logic                 ov_r, ov_nxt;
  lppf_pkg::status_t    ost_r, ost_nxt;
  logic [LEN_W-1:0]     olen_r, olen_nxt;
  logic [BYTE_W-1:0]    obyte_r, obyte_nxt;
  logic                 olast_r, olast_nxt;
  logic                 res_load;

  // store port
  logic              ram_we, ram_re;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;
  logic [2*BYTE_W-1:0] hdr_word;

  // fit check
  logic [CMP_W-1:0] gap, free_slots, need, len_ext;

  lppf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (lppf_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  // free space with one slot kept empty
  always_comb begin
    if (rp_r > wp_r) begin
      gap = CMP_W'(rp_r) - CMP_W'(wp_r);
    end else begin
      gap = CMP_W'(lppf_pkg::DEPTH) - (CMP_W'(wp_r) - CMP_W'(rp_r));
    end
    free_slots = gap - CMP_W'(1);
    len_ext    = CMP_W'(len_r);
    need       = len_ext + CMP_W'(2);
  end

  assign stat.op         = op_r;
  assign stat.wl_zero    = (wl_r == '0);
  assign stat.rl_zero    = (rl_r == '0);
  assign stat.wr_drop    = drop_r;
  assign stat.fits       = (len_ext <= CMP_W'(lppf_pkg::MAX_PACKET)) && (need <= free_slots);
  assign stat.fifo_empty = (rp_r == com_r);
  assign stat.out_free   = !ov_r || out_ready;

  // store write and read selection
  assign ram_we = cmd.start_hdr_hi | cmd.start_hdr_lo | cmd.data_store;
  assign ram_re = cmd.rd_hdr_hi | cmd.rd_hdr_lo | cmd.rd_byte;
  always_comb begin
    if (cmd.start_hdr_hi) begin
      ram_wdata = BYTE_W'(len_r >> BYTE_W);
    end else if (cmd.start_hdr_lo) begin
      ram_wdata = len_r[BYTE_W-1:0];
    end else begin
      ram_wdata = data_r;
    end
  end

  assign hdr_word = {hi_r, ram_rdata};
  assign res_load = cmd.start_reject | cmd.start_hdr_lo | cmd.data_store | cmd.data_drop
                  | cmd.hdr_done | cmd.byte_done | cmd.seq_err | cmd.fifo_empty;

  // state updates for each step
  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    com_nxt   = com_r;
    wl_nxt    = wl_r;
    rl_nxt    = rl_r;
    drop_nxt  = drop_r;
    ost_nxt   = lppf_pkg::STAT_OK;
    olen_nxt  = '0;
    obyte_nxt = '0;
    olast_nxt = 1'b0;

    if (ram_we) begin
      wp_nxt = next_slot(wp_r);
    end
    if (ram_re) begin
      rp_nxt = next_slot(rp_r);
    end

    if (cmd.start_reject) begin
      ost_nxt  = lppf_pkg::STAT_FULL;
      wl_nxt   = len_r;
      drop_nxt = 1'b1;
    end
    if (cmd.start_hdr_lo) begin
      wl_nxt   = len_r;
      drop_nxt = 1'b0;
      if (len_r == '0) begin
        com_nxt   = next_slot(wp_r);
        olast_nxt = 1'b1;
      end
    end
    if (cmd.data_store) begin
      wl_nxt = wl_r - 1'b1;
      if (wl_r == LEN_W'(1)) begin
        com_nxt   = next_slot(wp_r);
        olast_nxt = 1'b1;
      end
    end
    if (cmd.data_drop) begin
      ost_nxt = lppf_pkg::STAT_FULL;
      wl_nxt  = wl_r - 1'b1;
    end
    if (cmd.hdr_done) begin
      olen_nxt = hdr_word[LEN_W-1:0];
      rl_nxt   = hdr_word[LEN_W-1:0];
    end
    if (cmd.byte_done) begin
      obyte_nxt = ram_rdata;
      rl_nxt    = rl_r - 1'b1;
      olast_nxt = (rl_r == LEN_W'(1));
    end
    if (cmd.seq_err) begin
      ost_nxt = lppf_pkg::STAT_ORDER;
    end
    if (cmd.fifo_empty) begin
      ost_nxt = lppf_pkg::STAT_EMPTY;
    end

    if (res_load) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      com_r  <= '0;
      wl_r   <= '0;
      rl_r   <= '0;
      drop_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      com_r  <= com_nxt;
      wl_r   <= wl_nxt;
      rl_r   <= rl_nxt;
      drop_r <= drop_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      len_r  <= in_len;
      data_r <= in_data;
    end
    if (cmd.rd_hdr_lo) begin
      hi_r <= ram_rdata;
    end
    if (res_load) begin
      ost_r   <= ost_nxt;
      olen_r  <= olen_nxt;
      obyte_r <= obyte_nxt;
      olast_r <= olast_nxt;
    end
  end

  assign out_valid  = ov_r;
  assign out_status = ost_r;
  assign out_len    = olen_r;
  assign out_byte   = obyte_r;
  assign out_last   = olast_r;

endmodule

// File: hdl/length_prefixed_packet_fifo_unit.sv
// Result: registered as S_EXEC ends, or as S_WHDR ends for a start write, as S_RBYTE ends
//   for a data read and as S_RLEN ends for a header read. A new word is taken only once the
//   last is through, in steps set by the store's write and registered read ports (a header
//   is two store accesses); a waiting result holds the next word.
// Reset: synchronous, active low; pointers and counters clear, store contents are kept.
`timescale 1ns / 1ps

module length_prefixed_packet_fifo_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [lppf_pkg::IN_TDATA_W-1:0]      in_tdata,   // packet_length, data_byte
  input  logic [lppf_pkg::OP_W-1:0]            in_tuser,   // op
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [lppf_pkg::OUT_TDATA_W-1:0]     out_tdata,  // read_length, read_byte
  output logic [lppf_pkg::STAT_W-1:0]          out_tuser,  // status
  output logic                                 out_tlast   // last_byte
);

  localparam int LEN_W  = lppf_pkg::LEN_W;
  localparam int BYTE_W = lppf_pkg::BYTE_W;

  lppf_pkg::cmd_t    cmd;
  lppf_pkg::stat_t   stat;
  lppf_pkg::status_t out_status;
  logic [LEN_W-1:0]  out_len;
  logic [BYTE_W-1:0] out_byte;
  logic              res_load;

  lppf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lppf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (lppf_pkg::op_t'(in_tuser)),
    .in_len     (in_tdata[LEN_W-1:0]),
    .in_data    (in_tdata[LEN_W+BYTE_W-1:LEN_W]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_status),
    .out_len    (out_len),
    .out_byte   (out_byte),
    .out_last   (out_tlast)
  );

  assign out_tdata = lppf_pkg::OUT_TDATA_W'({out_byte, out_len});
  assign out_tuser = out_status;

  assign res_load = cmd.start_reject | cmd.start_hdr_lo | cmd.data_store | cmd.data_drop
                  | cmd.hdr_done | cmd.byte_done | cmd.seq_err | cmd.fifo_empty;

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_tvalid || out_tready))
    else $error("result register overwritten");

  // reads never run past the last committed packet
  a_read_committed: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_hdr_hi || cmd.rd_byte) |-> !stat.fifo_empty)
    else $error("read beyond committed data");

  // bytes of a rejected packet never reach the store
  a_drop_no_store: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.data_store |-> !stat.wr_drop)
    else $error("dropped byte stored");

  // a header read occupies three consecutive steps
  a_hdr_sequence: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_hdr_hi |=> cmd.rd_hdr_lo ##1 cmd.hdr_done)
    else $error("header read sequence broken");

endmodule
